/* src/dss_pkg.sv */
// Shared types, microcode program and control word layout for the descending sort block.
package dss_pkg;

  // One stored entry: the object tag and its signed 16.16 key.
  typedef struct packed {
    logic [15:0]        tag;
    logic signed [31:0] key;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  typedef logic [2:0] step_t;

  localparam step_t STEP_PASS      = 3'd0;
  localparam step_t STEP_FETCH     = 3'd1;
  localparam step_t STEP_SCAN      = 3'd2;
  localparam step_t STEP_WR_I      = 3'd3;
  localparam step_t STEP_WR_BEST   = 3'd4;
  localparam step_t STEP_EMIT_INIT = 3'd5;
  localparam step_t STEP_EMIT      = 3'd6;
  localparam step_t STEP_DONE      = 3'd7;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_I_LAST,
    COND_I_MORE,
    COND_J_MORE,
    COND_EMPTY
  } cond_e;

  typedef enum logic [1:0] {
    RA_I,
    RA_I_INC,
    RA_J_INC,
    RA_ZERO
  } raddr_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_AT_I,
    WR_AT_BEST
  } wsel_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic i_more;
    logic j_more;
    logic empty;
  } status_t;

  // One microcode control word.
  typedef struct packed {
    cond_e  cond;
    step_t  target;
    raddr_e raddr;
    wsel_e  wsel;
    logic   set_best;
    logic   cap_cur;
    logic   scan;
    logic   inc_i;
    logic   clr_i;
    logic   emit;
    logic   finish;
  } uword_t;

  // The sort and emit program: one selection pass per outer position, then a read-out loop.
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '0;
    w.cond = COND_NEXT;
    w.raddr = RA_I;
    w.wsel = WR_NONE;
    case (step)
      STEP_PASS: begin
        w.cond = COND_I_LAST;
        w.target = STEP_EMIT_INIT;
        w.raddr = RA_I;
        w.set_best = 1'b1;
      end
      STEP_FETCH: begin
        w.raddr = RA_I_INC;
        w.cap_cur = 1'b1;
      end
      STEP_SCAN: begin
        w.cond = COND_J_MORE;
        w.target = STEP_SCAN;
        w.raddr = RA_J_INC;
        w.scan = 1'b1;
      end
      STEP_WR_I: begin
        w.wsel = WR_AT_I;
      end
      STEP_WR_BEST: begin
        w.cond = COND_JUMP;
        w.target = STEP_PASS;
        w.wsel = WR_AT_BEST;
        w.inc_i = 1'b1;
      end
      STEP_EMIT_INIT: begin
        w.cond = COND_EMPTY;
        w.target = STEP_DONE;
        w.raddr = RA_ZERO;
        w.clr_i = 1'b1;
      end
      STEP_EMIT: begin
        w.cond = COND_I_MORE;
        w.target = STEP_EMIT;
        w.raddr = RA_I_INC;
        w.emit = 1'b1;
        w.inc_i = 1'b1;
      end
      STEP_DONE: begin
        w.clr_i = 1'b1;
        w.finish = 1'b1;
      end
      default: begin
        w.finish = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/descending_selection_sort.sv */
// Top level of the descending selection sort block.
//
//   Channel   Handshake                  Payload
//   input     start / busy               object_tag_i, y_position_i, last_item_i
//   result    result_valid_o (strobe)    sorted_tag_o, sorted_key_o, last_result_o,
//                                        items_dropped_o
//
// Items load one per cycle; busy stays low until an item marked last is taken.
// The sort then runs from a microcode table over one shared comparator and one store
// read port, one compare per cycle while a pass scans, then reads out one result per cycle.
// Reset clears the item count, the drop flag and the sequencer; the store needs no clearing.
// Results are strobed for one cycle each and cannot be held off by the receiver.
module descending_selection_sort #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] object_tag_i,
  input  logic [31:0] y_position_i,
  input  logic        last_item_i,
  output logic        result_valid_o,
  output logic [15:0] sorted_tag_o,
  output logic [31:0] sorted_key_o,
  output logic        last_result_o,
  output logic        items_dropped_o
);

  logic             accept;
  logic             seq_busy;
  dss_pkg::status_t status;
  dss_pkg::uword_t  ctl;
  dss_pkg::entry_t  result;

  assign accept = start && !seq_busy;
  assign busy   = seq_busy;

  dss_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (accept && last_item_i),
    .status_i (status),
    .ctl_o    (ctl),
    .busy_o   (seq_busy)
  );

  dss_datapath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .load_tag_i      (object_tag_i),
    .load_key_i      (y_position_i),
    .ctl_i           (ctl),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .result_o        (result),
    .last_result_o   (last_result_o),
    .items_dropped_o (items_dropped_o)
  );

  assign sorted_tag_o = result.tag;
  assign sorted_key_o = result.key;

`ifndef ASSERT_OFF
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobed while the block is idle");

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_item_i) |=> busy)
    else $error("last item taken but sort did not start");

  a_last_closes_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> !result_valid_o)
    else $error("result strobed after the final result of a set");
`endif

endmodule

/* src/dss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dss_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dss_seq.sv */
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module dss_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  dss_pkg::status_t status_i,
  output dss_pkg::uword_t  ctl_o,
  output logic             busy_o
);

  dss_pkg::seq_state_e state_q, state_d;
  dss_pkg::step_t      upc_q, upc_d;
  logic                take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dss_pkg::SEQ_IDLE;
      upc_q   <= dss_pkg::STEP_PASS;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    ctl_o   = '0;
    take    = 1'b0;
    busy_o  = (state_q == dss_pkg::SEQ_RUN);
    case (state_q)
      dss_pkg::SEQ_IDLE: begin
        if (go_i) begin
          state_d = dss_pkg::SEQ_RUN;
          upc_d   = dss_pkg::STEP_PASS;
        end
      end
      dss_pkg::SEQ_RUN: begin
        ctl_o = dss_pkg::ucode_rom(upc_q);
        case (ctl_o.cond)
          dss_pkg::COND_NEXT:   take = 1'b0;
          dss_pkg::COND_JUMP:   take = 1'b1;
          dss_pkg::COND_I_LAST: take = !status_i.i_more;
          dss_pkg::COND_I_MORE: take = status_i.i_more;
          dss_pkg::COND_J_MORE: take = status_i.j_more;
          dss_pkg::COND_EMPTY:  take = status_i.empty;
          default:              take = 1'b0;
        endcase
        upc_d = take ? ctl_o.target : upc_q + 3'd1;
        if (ctl_o.finish) begin
          state_d = dss_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = dss_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

/* src/dss_datapath.sv */
// Datapath: entry store, load counter, pass indexes, key comparator and result registers.
module dss_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [15:0]      load_tag_i,
  input  logic [31:0]      load_key_i,
  input  dss_pkg::uword_t  ctl_i,
  output dss_pkg::status_t status_o,
  output logic             result_valid_o,
  output dss_pkg::entry_t  result_o,
  output logic             last_result_o,
  output logic             items_dropped_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]   count_q, i_q, j_q, best_q;
  logic [CW-1:0]   i_inc, j_inc;
  logic            overflow_q, valid_q;
  logic            room;
  logic            greater;

  dss_pkg::entry_t best_ent_q, cur_ent_q, out_ent_q, rd_ent, wdata;
  logic            out_last_q, out_drop_q;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [dss_pkg::EntryWidth-1:0] rdata;

  assign i_inc = i_q + CW'(1);
  assign j_inc = j_q + CW'(1);
  assign room  = count_q < CW'(MAX_ITEMS);

  assign status_o.i_more = i_inc < count_q;
  assign status_o.j_more = j_inc < count_q;
  assign status_o.empty  = (count_q == '0);

  assign rd_ent  = dss_pkg::entry_t'(rdata);
  assign greater = $signed(rd_ent.key) > $signed(best_ent_q.key);

  always_comb begin
    case (ctl_i.raddr)
      dss_pkg::RA_I:     raddr = i_q[AW-1:0];
      dss_pkg::RA_I_INC: raddr = i_inc[AW-1:0];
      dss_pkg::RA_J_INC: raddr = j_inc[AW-1:0];
      dss_pkg::RA_ZERO:  raddr = '0;
      default:           raddr = '0;
    endcase
  end

  // Microcode writes only happen while the sequencer runs, so loads never collide with them.
  always_comb begin
    case (ctl_i.wsel)
      dss_pkg::WR_AT_I: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = best_ent_q;
      end
      dss_pkg::WR_AT_BEST: begin
        we    = 1'b1;
        waddr = best_q[AW-1:0];
        wdata = cur_ent_q;
      end
      default: begin
        we        = load_i && room;
        waddr     = count_q[AW-1:0];
        wdata.tag = load_tag_i;
        wdata.key = load_key_i;
      end
    endcase
  end

  dss_ram #(
    .WIDTH(dss_pkg::EntryWidth),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
      i_q        <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (ctl_i.finish) begin
        count_q    <= '0;
        overflow_q <= 1'b0;
      end else if (load_i) begin
        if (room) begin
          count_q <= count_q + CW'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (ctl_i.clr_i) begin
        i_q <= '0;
      end else if (ctl_i.inc_i) begin
        i_q <= i_inc;
      end
      valid_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.set_best) begin
      best_q <= i_q;
      j_q    <= i_inc;
    end else if (ctl_i.scan) begin
      j_q <= j_inc;
      // Strictly greater only, so the earliest maximum of the pass is kept.
      if (greater) begin
        best_q     <= j_q;
        best_ent_q <= rd_ent;
      end
    end
    if (ctl_i.cap_cur) begin
      best_ent_q <= rd_ent;
      cur_ent_q  <= rd_ent;
    end
    if (ctl_i.emit) begin
      out_ent_q  <= rd_ent;
      out_last_q <= !status_o.i_more;
      out_drop_q <= overflow_q;
    end
  end

  assign result_valid_o  = valid_q;
  assign result_o        = out_ent_q;
  assign last_result_o   = out_last_q;
  assign items_dropped_o = out_drop_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("stored item count exceeds capacity");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.scan |-> (best_q < j_q) && (j_q < count_q))
    else $error("scan index out of order or beyond stored items");

  a_no_load_on_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.wsel != dss_pkg::WR_NONE) |-> !load_i)
    else $error("item loaded while a swap writes the store");
`endif

endmodule

/* sim/descending_selection_sort_checker.sv */
// Checker that predicts the sorted read-out of every loaded set and compares it with the block.
module descending_selection_sort_checker #(
  parameter int unsigned Capacity = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] object_tag_i,
  input  logic [31:0] y_position_i,
  input  logic        last_item_i,
  input  logic        result_valid_i,
  input  logic [15:0] sorted_tag_i,
  input  logic [31:0] sorted_key_i,
  input  logic        last_result_i,
  input  logic        items_dropped_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    dss_pkg::entry_t entry;
    logic            last;
    logic            dropped;
  } sorted_result_t;

  dss_pkg::entry_t loaded_set[$];
  logic            overflow_seen;
  sorted_result_t  pending_sorted[$];
  int unsigned     errors = 0;

  // The earliest strict maximum of the remaining entries is swapped into place on each pass.
  function automatic void sort_loaded_set();
    int unsigned     i;
    int unsigned     j;
    int unsigned     best;
    dss_pkg::entry_t held;
    for (i = 0; i + 1 < loaded_set.size(); i++) begin
      best = i;
      for (j = i + 1; j < loaded_set.size(); j++) begin
        if ($signed(loaded_set[j].key) > $signed(loaded_set[best].key)) begin
          best = j;
        end
      end
      held = loaded_set[i];
      loaded_set[i] = loaded_set[best];
      loaded_set[best] = held;
    end
  endfunction

  function automatic void take_item();
    dss_pkg::entry_t item;
    sorted_result_t  due;
    int unsigned     k;
    item.tag = object_tag_i;
    item.key = y_position_i;
    if (loaded_set.size() < Capacity) begin
      loaded_set = {loaded_set, item};
    end else begin
      overflow_seen = 1'b1;
    end
    if (last_item_i) begin
      sort_loaded_set();
      for (k = 0; k < loaded_set.size(); k++) begin
        due.entry = loaded_set[k];
        due.last = (k + 1 == loaded_set.size());
        due.dropped = overflow_seen;
        pending_sorted = {pending_sorted, due};
      end
      loaded_set.delete();
      overflow_seen = 1'b0;
    end
  endfunction

  function automatic void check_result();
    sorted_result_t due;
    if (pending_sorted.size() == 0) begin
      $error("sorted result with none expected: tag %h key %h", sorted_tag_i, sorted_key_i);
      errors++;
    end else begin
      due = pending_sorted.pop_front();
      if (sorted_tag_i !== due.entry.tag) begin
        $error("sorted_tag expected %h actual %h", due.entry.tag, sorted_tag_i);
        errors++;
      end
      if (sorted_key_i !== due.entry.key) begin
        $error("sorted_key expected %h actual %h", due.entry.key, sorted_key_i);
        errors++;
      end
      if (last_result_i !== due.last) begin
        $error("last_result expected %b actual %b", due.last, last_result_i);
        errors++;
      end
      if (items_dropped_i !== due.dropped) begin
        $error("items_dropped expected %b actual %b", due.dropped, items_dropped_i);
        errors++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_set.delete();
      pending_sorted.delete();
      overflow_seen = 1'b0;
    end else begin
      if (result_valid_i) begin
        check_result();
      end
      if (start_i && !busy_i) begin
        take_item();
      end
    end
    pending_o = pending_sorted.size();
    error_count_o = errors;
  end

endmodule

/* sim/descending_selection_sort_test.sv */
// Testbench top that loads sets of tagged keys into the sort block and gives the verdict.
module descending_selection_sort_test;

  localparam int unsigned Capacity = 64;
  localparam int unsigned RandItems = 170;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] object_tag_i;
  logic [31:0] y_position_i;
  logic        last_item_i;
  logic        result_valid_o;
  logic [15:0] sorted_tag_o;
  logic [31:0] sorted_key_o;
  logic        last_result_o;
  logic        items_dropped_o;

  int unsigned failures;
  int unsigned pending_results;
  int unsigned items_sent;
  int unsigned idle_pct;
  int unsigned set_index;
  int unsigned set_size;
  int unsigned set_mode;
  int unsigned rand_base;
  logic [15:0] set_tags[$];
  logic [31:0] set_keys[$];

  always #5 clk_i = ~clk_i;

  descending_selection_sort #(
    .MAX_ITEMS(Capacity)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .object_tag_i   (object_tag_i),
    .y_position_i   (y_position_i),
    .last_item_i    (last_item_i),
    .result_valid_o (result_valid_o),
    .sorted_tag_o   (sorted_tag_o),
    .sorted_key_o   (sorted_key_o),
    .last_result_o  (last_result_o),
    .items_dropped_o(items_dropped_o)
  );

  descending_selection_sort_checker #(
    .Capacity(Capacity)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .object_tag_i   (object_tag_i),
    .y_position_i   (y_position_i),
    .last_item_i    (last_item_i),
    .result_valid_i (result_valid_o),
    .sorted_tag_i   (sorted_tag_o),
    .sorted_key_i   (sorted_key_o),
    .last_result_i  (last_result_o),
    .items_dropped_i(items_dropped_o),
    .error_count_o  (failures),
    .pending_o      (pending_results)
  );

  // Keys for random sets: full range, a few heavily repeated values, or a narrow 16.16 band.
  function automatic logic [31:0] pick_key(input int unsigned mode);
    logic [31:0] key;
    case (mode)
      0: key = $urandom;
      1: begin
        case ($urandom_range(4))
          0: key = 32'h8000_0000;
          1: key = 32'h7fff_ffff;
          2: key = 32'hffff_ffff;
          3: key = 32'h0000_0000;
          default: key = 32'h0001_0000;
        endcase
      end
      default: key = 32'($urandom_range(0, 32'h003f_ffff)) - 32'h0020_0000;
    endcase
    return key;
  endfunction

  // Called at a falling edge; returns at a falling edge after the take and any idle gap.
  task automatic send_item(input logic [15:0] tag, input logic [31:0] key, input logic last);
    start = 1'b1;
    object_tag_i = tag;
    y_position_i = key;
    last_item_i = last;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    items_sent++;
    case ((items_sent / 50) % 3)
      0: idle_pct = 0;
      1: idle_pct = 62;
      default: idle_pct = 12;
    endcase
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) begin
        object_tag_i = 16'($urandom);
        y_position_i = $urandom;
        last_item_i = 1'($urandom_range(1));
        @(negedge clk_i);
      end
    end
  endtask

  task automatic send_loaded_set();
    int unsigned k;
    for (k = 0; k < set_keys.size(); k++) begin
      send_item(set_tags[k], set_keys[k], k + 1 == set_keys.size());
    end
  endtask

  task automatic wait_all_sorted();
    start = 1'b0;
    while (pending_results != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    object_tag_i = '0;
    y_position_i = '0;
    last_item_i = 1'b0;
    items_sent = 0;
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Single-item sets at both ends of the key range.
    set_tags = '{16'h0000};
    set_keys = '{32'h8000_0000};
    send_loaded_set();
    set_tags = '{16'hffff};
    set_keys = '{32'h7fff_ffff};
    send_loaded_set();
    set_tags = '{16'haaaa, 16'h5555, 16'h0001, 16'h8000, 16'h7fff};
    set_keys = '{32'hffff_ffff, 32'h0000_0000, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001};
    send_loaded_set();
    // Equal keys come out in the order that the swaps leave them.
    set_tags = '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006};
    set_keys = '{32'h0005_0000, 32'h0005_0000, 32'h0007_0000,
                 32'h0005_0000, 32'h0007_0000, 32'h0005_0000};
    send_loaded_set();
    set_tags = '{16'h0010, 16'h0011, 16'h0012};
    set_keys = '{32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
    send_loaded_set();
    set_tags = '{16'h0020, 16'h0021, 16'h0022};
    set_keys = '{32'hfffd_0000, 32'hfffe_0000, 32'hffff_0000};
    send_loaded_set();
    set_tags = '{16'h0030, 16'h0031, 16'h0032, 16'h0033};
    set_keys = '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000};
    send_loaded_set();
    wait_all_sorted();

    // Random sets; a full set and an overflowing one are placed early among them.
    rand_base = items_sent;
    set_index = 0;
    while (items_sent - rand_base < RandItems) begin
      case (set_index)
        1: set_size = Capacity;
        2: set_size = Capacity + 3;
        default: set_size = ($urandom_range(7) == 0) ? $urandom_range(11, 40)
                                                     : $urandom_range(1, 10);
      endcase
      set_mode = $urandom_range(2);
      set_tags.delete();
      set_keys.delete();
      repeat (set_size) begin
        set_tags = {set_tags, 16'($urandom)};
        set_keys = {set_keys, pick_key(($urandom_range(3) == 0) ? 0 : set_mode)};
      end
      send_loaded_set();
      if ($urandom_range(5) == 0) begin
        wait_all_sorted();
      end
      set_index++;
    end

    wait_all_sorted();
    repeat (100) @(negedge clk_i);
    if (failures == 0 && pending_results == 0) begin
      $display("descending_selection_sort_test passed");
    end else begin
      $display("descending_selection_sort_test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("descending_selection_sort_test failed");
    $finish;
  end

endmodule

/* files.f */
src/dss_pkg.sv
src/dss_ram.sv
src/dss_seq.sv
src/dss_datapath.sv
src/descending_selection_sort.sv
sim/descending_selection_sort_checker.sv
sim/descending_selection_sort_test.sv
